@@ hdl/sts_pkg.sv @@
// Shared types and constants for the servo trajectory smoother.
package sts_pkg;

	localparam int NUM_JOINTS  = 5;
	localparam int EASE_JOINTS = 4;
	localparam int QUEUE_DEPTH = 4;

	localparam int MAX_STEPS_DEF = 40;
	localparam int TICK_MS_DEF   = 20;
	localparam int MOVE_MS_DEF   = 3000;

	typedef logic [15:0] angle_t;
	typedef logic [16:0] frac_t;
	typedef logic [12:0] duty_t;
	typedef logic [1:0]  phase_t;

	localparam angle_t ANGLE_MAX   = 16'd46080;
	localparam angle_t ONE_DEG     = 16'd256;
	localparam frac_t  FRAC_ONE    = 17'd65536;
	localparam duty_t  DUTY_OFFSET = 13'd1280;
	localparam phase_t PHASE_LAST  = 2'd3;

	// joint 0 in the low word
	localparam angle_t [NUM_JOINTS-1:0] RESET_ANGLE = {
		16'd39680, 16'd23040, 16'd40960, 16'd17920, 16'd23040
	};

	typedef struct packed {
		angle_t [NUM_JOINTS-1:0] target;
		frac_t                   frac;
		logic                    snap;
		logic                    mode;
		phase_t                  phase;
	} sts_entry_t;

endpackage

@@ hdl/sts_front.sv @@
// Input side: button edge detection, mode/phase/step registers and ease lookup.
module sts_front import sts_pkg::*; #(
	parameter int MAX_STEPS = MAX_STEPS_DEF,
	parameter int TICK_MS   = TICK_MS_DEF,
	parameter int MOVE_MS   = MOVE_MS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    button_level,
	input  angle_t [NUM_JOINTS-1:0] target,
	input  logic                    queue_full,
	output logic                    push,
	output sts_entry_t              entry
);

	localparam int STEP_W = $clog2(MAX_STEPS + 2);
	localparam int IDX_W  = $clog2(MAX_STEPS + 1);
	localparam logic [STEP_W-1:0] STEP_SAT = STEP_W'(MAX_STEPS + 1);
	localparam logic [63:0] EASE_DEN = 64'(MOVE_MS) * 64'(MOVE_MS) * 64'(MOVE_MS);

	typedef logic [MAX_STEPS:0][16:0] ease_tab_t;

	// 3u^2 - 2u^3 in Q1.16, rounded, u clamped at 1
	function automatic ease_tab_t ease_table();
		ease_tab_t   tab;
		logic [63:0] s;
		logic [63:0] num;
		for (int i = 0; i <= MAX_STEPS; i++) begin
			s = 64'(i) * 64'(TICK_MS);
			if (s >= 64'(MOVE_MS)) begin
				tab[i] = FRAC_ONE;
			end else begin
				num    = s * s * (64'(3 * MOVE_MS) - 2 * s);
				tab[i] = 17'((num * 64'd65536 + EASE_DEN / 2) / EASE_DEN);
			end
		end
		return tab;
	endfunction

	localparam ease_tab_t EASE_TAB = ease_table();

	logic              released_q;
	logic              mode_q;
	phase_t            phase_q;
	logic [STEP_W-1:0] step_q;

	logic              press;
	logic              released_new;
	logic              mode_new;
	phase_t            phase_new;
	logic [STEP_W-1:0] step_base;
	logic [STEP_W-1:0] step_new;
	logic              snap;
	logic [IDX_W-1:0]  ease_idx;

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		press     = button_level && released_q;
		step_base = press ? '0 : step_q;
		step_new  = (step_base < STEP_SAT) ? step_base + 1'b1 : step_base;
		snap      = (step_new == STEP_SAT);
		ease_idx  = snap ? '0 : step_new[IDX_W-1:0];

		if (press) begin
			released_new = 1'b0;
			if (phase_q == PHASE_LAST) begin
				phase_new = '0;
				mode_new  = 1'b0;
			end else begin
				phase_new = phase_q + 1'b1;
				mode_new  = !mode_q;
			end
		end else begin
			released_new = released_q || !button_level;
			phase_new    = phase_q;
			mode_new     = mode_q;
		end
	end

	always_comb begin
		for (int j = 0; j < NUM_JOINTS; j++) begin
			entry.target[j] = (target[j] > ANGLE_MAX) ? ANGLE_MAX : target[j];
		end
		entry.frac  = snap ? FRAC_ONE : EASE_TAB[ease_idx];
		entry.snap  = snap;
		entry.mode  = mode_new;
		entry.phase = phase_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			released_q <= 1'b1;
			mode_q     <= 1'b0;
			phase_q    <= '0;
			step_q     <= '0;
		end else if (push) begin
			released_q <= released_new;
			mode_q     <= mode_new;
			phase_q    <= phase_new;
			step_q     <= step_new;
		end
	end

endmodule

@@ hdl/sts_queue.sv @@
// Short FIFO between the input side and the joint pipeline.
module sts_queue import sts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  sts_entry_t wr_entry,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output sts_entry_t rd_entry
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	sts_entry_t       slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_entry  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/sts_back.sv @@
// Joint pipeline: eased angle update, then duty conversion into the output register.
module sts_back import sts_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_not_empty,
	input  sts_entry_t             q_entry,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output duty_t [NUM_JOINTS-1:0] duty,
	output logic                   mode_flag,
	output phase_t                 phase_count
);

	// x/9 == (x * 116509) >> 20 for x below 2^17
	localparam logic [16:0] DIV9_MUL   = 17'd116509;
	localparam int          DIV9_SHIFT = 20;

	angle_t [NUM_JOINTS-1:0] angle_q;
	logic                    valid_s1;
	logic                    mode_s1;
	phase_t                  phase_s1;

	angle_t [NUM_JOINTS-1:0]  angle_next;
	angle_t [EASE_JOINTS-1:0] eased;
	duty_t  [NUM_JOINTS-1:0]  duty_next;
	angle_t                   j1_diff;
	logic                     out_load;

	assign out_load = valid_s1 && (!out_valid || !out_stall);
	assign pop      = q_not_empty && (!valid_s1 || out_load);

	// eased joints: move by frac of the remaining distance, rounded
	for (genvar j = 0; j < EASE_JOINTS; j++) begin : g_ease
		angle_t      a;
		angle_t      t;
		logic        up;
		angle_t      gap;
		logic [33:0] prod;
		angle_t      move;
		assign a        = angle_q[j];
		assign t        = q_entry.target[j];
		assign up       = (t >= a);
		assign gap      = up ? t - a : a - t;
		assign prod     = 34'(q_entry.frac) * 34'(gap) + 34'd32768;
		assign move     = prod[31:16];
		assign eased[j] = up ? a + move : a - move;
	end

	always_comb begin
		for (int j = 0; j < EASE_JOINTS; j++) begin
			angle_next[j] = q_entry.snap ? q_entry.target[j] : eased[j];
		end

		// joint 1 creeps a further degree toward its target
		j1_diff = (angle_next[1] > q_entry.target[1]) ? angle_next[1] - q_entry.target[1]
		                                              : q_entry.target[1] - angle_next[1];
		if (j1_diff < ONE_DEG) begin
			angle_next[1] = q_entry.target[1];
		end else if (angle_next[1] > q_entry.target[1]) begin
			angle_next[1] = angle_next[1] - ONE_DEG;
		end else begin
			angle_next[1] = angle_next[1] + ONE_DEG;
		end

		angle_next[NUM_JOINTS-1] = q_entry.target[NUM_JOINTS-1];
	end

	for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_duty
		logic [16:0] x;
		logic [33:0] p;
		assign x            = 17'(angle_q[j]) + 17'd4;
		assign p            = 34'(x) * 34'(DIV9_MUL);
		assign duty_next[j] = p[DIV9_SHIFT +: 13] + DUTY_OFFSET;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q  <= RESET_ANGLE;
			valid_s1 <= 1'b0;
		end else if (pop) begin
			angle_q  <= angle_next;
			valid_s1 <= 1'b1;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mode_s1  <= q_entry.mode;
			phase_s1 <= q_entry.phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			duty        <= duty_next;
			mode_flag   <= mode_s1;
			phase_count <= phase_s1;
		end
	end

endmodule

@@ hdl/servo_trajectory_smoother_core.sv @@
// Top level of the servo trajectory smoother: input side, queue and joint pipeline.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   in      | into core | in_valid/in_stall   | button_level, target_0..target_4
//   out     | from core | out_valid/out_stall | duty_0..duty_4, mode_flag, phase_count
//
// One tick per clock sustained while the output is not stalled; a transfer on
// the input reaches the output register through the queue write, then the angle
// update, then the duty conversion, after which the result can transfer.
// The angle update is a feedback loop through the angle registers: one ease
// multiply per eased joint followed by the joint 1 degree step.
// Reset puts the joints at 90, 70, 160, 90, 155 degrees, button released,
// mode and phase zero. A stalled output backs up the pipeline into the
// four-entry queue; in_stall rises only once that queue is full.
module servo_trajectory_smoother_core import sts_pkg::*; #(
	parameter int MAX_STEPS = MAX_STEPS_DEF,
	parameter int TICK_MS   = TICK_MS_DEF,
	parameter int MOVE_MS   = MOVE_MS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  logic   button_level,
	input  angle_t target_0,
	input  angle_t target_1,
	input  angle_t target_2,
	input  angle_t target_3,
	input  angle_t target_4,
	output logic   out_valid,
	input  logic   out_stall,
	output duty_t  duty_0,
	output duty_t  duty_1,
	output duty_t  duty_2,
	output duty_t  duty_3,
	output duty_t  duty_4,
	output logic   mode_flag,
	output phase_t phase_count
);

	angle_t [NUM_JOINTS-1:0] target;
	duty_t  [NUM_JOINTS-1:0] duty;
	sts_entry_t              wr_entry;
	sts_entry_t              rd_entry;
	logic                    push;
	logic                    pop;
	logic                    q_full;
	logic                    q_not_empty;

	assign target = {target_4, target_3, target_2, target_1, target_0};
	assign duty_0 = duty[0];
	assign duty_1 = duty[1];
	assign duty_2 = duty[2];
	assign duty_3 = duty[3];
	assign duty_4 = duty[4];

	// front: edge detect, phase/mode/step bookkeeping, ease fraction lookup
	sts_front #(
		.MAX_STEPS (MAX_STEPS),
		.TICK_MS   (TICK_MS),
		.MOVE_MS   (MOVE_MS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.button_level (button_level),
		.target       (target),
		.queue_full   (q_full),
		.push         (push),
		.entry        (wr_entry)
	);

	// decouples the front from output back-pressure
	sts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.rd_entry  (rd_entry)
	);

	// back: joint angle state and duty output register
	sts_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_entry     (rd_entry),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.duty        (duty),
		.mode_flag   (mode_flag),
		.phase_count (phase_count)
	);

endmodule
